// ===== rtl/trz_pkg.sv =====
// ----------------------------------------------------------------------------
// trz_pkg: shared types and constants for the tile rasterizer
// Tile size, field widths and the control bundle of the multiply unit.
// ----------------------------------------------------------------------------
package trz_pkg;

	localparam int TILE_W = 8;
	localparam int TILE_H = 8;
	localparam int NPIX   = TILE_W * TILE_H;
	localparam int ADDR_W = $clog2(NPIX);
	localparam int PX_W   = 3;

	localparam int CRD_W  = 12;   // vertex coordinate
	localparam int DEP_W  = 16;   // Q1.14 depth
	localparam int PNT_W  = 24;   // packed color
	localparam int DIF_W  = 13;   // coordinate difference
	localparam int OPA_W  = 28;   // multiplier wide operand
	localparam int OPB_W  = 16;   // multiplier narrow operand
	localparam int ACC_W  = OPA_W + OPB_W;
	localparam int CRS_W  = 27;   // cross product terms
	localparam int QUO_W  = 16;   // quotient magnitude bits

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 48;

	localparam logic signed [DEP_W-1:0] DEPTH_MIN = {1'b1, {(DEP_W-1){1'b0}}};

	typedef struct packed {
		logic en;
		logic clr;
		logic sub;
	} mac_op_t;

endpackage

// ===== rtl/trz_mac.sv =====
// ----------------------------------------------------------------------------
// trz_mac: shared signed multiply-accumulate unit
// One 28x16 signed product per cycle, added to or subtracted from the sum.
// ----------------------------------------------------------------------------
module trz_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  trz_pkg::mac_op_t                    op,
	input  logic signed [trz_pkg::OPA_W-1:0]    a,
	input  logic signed [trz_pkg::OPB_W-1:0]    b,
	output logic signed [trz_pkg::ACC_W-1:0]    acc
);
	import trz_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = a * b;
	assign base = op.clr ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op.en) begin
			acc_q <= op.sub ? (base - prod) : (base + prod);
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/trz_div.sv =====
// ----------------------------------------------------------------------------
// trz_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module trz_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [trz_pkg::ACC_W-1:0]       dividend,
	input  logic [trz_pkg::CRS_W-1:0]       divisor,
	output logic                            done,
	output logic [trz_pkg::QUO_W-1:0]       quotient
);
	import trz_pkg::*;

	localparam int DSH_W = CRS_W + QUO_W - 1;
	localparam int CNT_W = $clog2(QUO_W);

	logic [ACC_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [ACC_W-1:0] dsh_ext;
	logic             ge;

	assign dsh_ext = ACC_W'(dsh_q);
	assign ge      = rem_q >= dsh_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_ext;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/trz_depth_mem.sv =====
// ----------------------------------------------------------------------------
// trz_depth_mem: tile depth store
// One write and one registered read port; per-entry valid bits give the
// cleared value without a sweep.
// ----------------------------------------------------------------------------
module trz_depth_mem (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clr,
	input  logic                                we,
	input  logic [trz_pkg::ADDR_W-1:0]          waddr,
	input  logic signed [trz_pkg::DEP_W-1:0]    wdata,
	input  logic [trz_pkg::ADDR_W-1:0]          raddr,
	output logic signed [trz_pkg::DEP_W-1:0]    rdata
);
	import trz_pkg::*;

	logic signed [DEP_W-1:0] mem [NPIX];
	logic [NPIX-1:0]         vld_q;
	logic signed [DEP_W-1:0] rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : DEPTH_MIN;

endmodule

// ===== rtl/triangle_raster_zbuffer.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_zbuffer: 8x8 tile rasterizer with depth test
// Walks the clamped bounding box, tests barycentric weights and updates a
// depth store on nearer pixels; one result request per visited pixel.
// ----------------------------------------------------------------------------
// Sequence: setup in UZ0, UZ1, UZF; per pixel UX0, UX1, UY0, UY1 and CHK, then for
//   pixels inside N0, N1, N2, DST and DIV; every pixel ends in OUT, held on stall.
// Throughput: one triangle at a time, up to 64 pixels; s_tready only in idle.
//   The per-pixel time is set by the single shared multiplier (up to 7 products)
//   and the bit-serial divider. A clear request is accepted only in idle.
// Reset: arst_n clears control and the depth store valid bits at once, so
//   every depth entry reads as most negative; no clearing pass is needed.
module triangle_raster_zbuffer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// ax[11:0] ay[23:12] az[39:24] bx[51:40] by[63:52] bz[79:64]
	// cx[91:80] cy[103:92] cz[119:104] paint[143:120]
	input  logic [trz_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// px[2:0] py[5:3] depth_out[21:6] paint_out[45:22], zero pad [47:46]
	output logic [trz_pkg::OUT_DATA_W-1:0]      m_tdata,
	// drawn[0]
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import trz_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_UZ0  = 15'b000000000000010,
		S_UZ1  = 15'b000000000000100,
		S_UZF  = 15'b000000000001000,
		S_UX0  = 15'b000000000010000,
		S_UX1  = 15'b000000000100000,
		S_UY0  = 15'b000000001000000,
		S_UY1  = 15'b000000010000000,
		S_CHK  = 15'b000000100000000,
		S_N0   = 15'b000001000000000,
		S_N1   = 15'b000010000000000,
		S_N2   = 15'b000100000000000,
		S_DST  = 15'b001000000000000,
		S_DIV  = 15'b010000000000000,
		S_OUT  = 15'b100000000000000
	} state_t;

	// clamp a signed coordinate into [0, hi]
	function automatic logic [PX_W-1:0] clamp_crd(input logic signed [CRD_W-1:0] v,
			input logic [PX_W-1:0] hi);
		logic signed [CRD_W-1:0] hs;
		hs = $signed(CRD_W'(hi));
		if (v < 0) begin
			return '0;
		end else if (v > hs) begin
			return hi;
		end else begin
			return v[PX_W-1:0];
		end
	endfunction

	localparam logic [PX_W-1:0] XMAX = PX_W'(TILE_W - 1);
	localparam logic [PX_W-1:0] YMAX = PX_W'(TILE_H - 1);

	state_t state_q;

	// input fields
	logic signed [CRD_W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
	logic signed [CRD_W-1:0] mnx, mxx, mny, mxy;

	assign in_ax = s_tdata[11:0];
	assign in_ay = s_tdata[23:12];
	assign in_bx = s_tdata[51:40];
	assign in_by = s_tdata[63:52];
	assign in_cx = s_tdata[91:80];
	assign in_cy = s_tdata[103:92];

	always_comb begin
		mnx = (in_ax < in_bx) ? in_ax : in_bx;
		mnx = (mnx < in_cx) ? mnx : in_cx;
		mxx = (in_ax > in_bx) ? in_ax : in_bx;
		mxx = (mxx > in_cx) ? mxx : in_cx;
		mny = (in_ay < in_by) ? in_ay : in_by;
		mny = (mny < in_cy) ? mny : in_cy;
		mxy = (in_ay > in_by) ? in_ay : in_by;
		mxy = (mxy > in_cy) ? mxy : in_cy;
	end

	// triangle registers
	logic signed [CRD_W-1:0] ax_q, ay_q;
	logic signed [DEP_W-1:0] az_q, bz_q, cz_q;
	logic [PNT_W-1:0]        paint_q;
	logic signed [DIF_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [PX_W-1:0]         xlo_q, xhi_q, yhi_q, px_q, py_q;

	// cross product and depth registers
	logic [CRS_W-1:0]        uz_q;
	logic                    uz_neg_q;
	logic                    deg_q;
	logic signed [CRS_W-1:0] ux_q, uy_q, w0_q;
	logic                    inside_q;
	logic                    num_neg_q;

	// shared units
	mac_op_t                 mac_op;
	logic signed [OPA_W-1:0] mac_a;
	logic signed [OPB_W-1:0] mac_b;
	logic signed [ACC_W-1:0] acc;
	logic                    div_start;
	logic [ACC_W-1:0]        acc_mag;
	logic                    div_done;
	logic [QUO_W-1:0]        quo;

	// pixel offsets x2 = ax - px, y2 = ay - py
	logic signed [DIF_W-1:0] x2, y2;
	assign x2 = DIF_W'(ax_q) - $signed({{(DIF_W-PX_W){1'b0}}, px_q});
	assign y2 = DIF_W'(ay_q) - $signed({{(DIF_W-PX_W){1'b0}}, py_q});

	// sign-corrected term straight off the accumulator
	logic signed [CRS_W-1:0] acc_crs;
	logic signed [CRS_W-1:0] acc_fix;
	logic signed [CRS_W+1:0] w0_c;
	logic                    inside_c;

	assign acc_crs  = acc[CRS_W-1:0];
	assign acc_fix  = uz_neg_q ? -acc_crs : acc_crs;
	assign w0_c     = (CRS_W+2)'($signed({1'b0, uz_q})) - (CRS_W+2)'(ux_q)
			- (CRS_W+2)'(acc_fix);
	assign inside_c = !deg_q && (w0_c >= 0) && (ux_q >= 0) && (acc_fix >= 0);
	assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

	// multiplier operand selection
	always_comb begin
		mac_op = '0;
		mac_a  = '0;
		mac_b  = '0;
		unique case (state_q)
			S_UZ0: begin
				mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a  = OPA_W'(x0_q);
				mac_b  = OPB_W'(y1_q);
			end
			S_UZ1: begin
				mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a  = OPA_W'(x1_q);
				mac_b  = OPB_W'(y0_q);
			end
			S_UX0: begin
				mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a  = OPA_W'(x1_q);
				mac_b  = OPB_W'(y2);
			end
			S_UX1: begin
				mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a  = OPA_W'(x2);
				mac_b  = OPB_W'(y1_q);
			end
			S_UY0: begin
				mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a  = OPA_W'(x2);
				mac_b  = OPB_W'(y0_q);
			end
			S_UY1: begin
				mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
				mac_a  = OPA_W'(x0_q);
				mac_b  = OPB_W'(y2);
			end
			S_N0: begin
				mac_op = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
				mac_a  = OPA_W'(w0_q);
				mac_b  = az_q;
			end
			S_N1: begin
				mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
				mac_a  = OPA_W'(ux_q);
				mac_b  = bz_q;
			end
			S_N2: begin
				mac_op = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
				mac_a  = OPA_W'(uy_q);
				mac_b  = cz_q;
			end
			S_IDLE, S_UZF, S_CHK, S_DST, S_DIV, S_OUT: begin
				mac_op = '0;
			end
			default: begin
				mac_op = '0;
			end
		endcase
	end

	assign div_start = (state_q == S_DST);

	trz_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	trz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_mag),
		.divisor  (uz_q),
		.done     (div_done),
		.quotient (quo)
	);

	// depth test
	logic [ADDR_W-1:0]       pix_addr;
	logic signed [DEP_W-1:0] stored;
	logic signed [DEP_W-1:0] depth;
	logic                    drawn;
	logic                    out_free;
	logic                    last_pix;
	logic                    mem_we;
	logic                    mem_clr;

	assign pix_addr = ADDR_W'(py_q) * ADDR_W'(TILE_W) + ADDR_W'(px_q);
	assign depth    = num_neg_q ? DEP_W'(-quo) : DEP_W'(quo);
	assign drawn    = inside_q && (stored < depth);
	assign out_free = !m_tvalid || m_tready;
	assign last_pix = (px_q == xhi_q) && (py_q == yhi_q);
	assign mem_we   = (state_q == S_OUT) && out_free && drawn;
	assign mem_clr  = (state_q == S_IDLE) && s_tvalid && s_tuser;

	trz_depth_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (pix_addr),
		.wdata  (depth),
		.raddr  (pix_addr),
		.rdata  (stored)
	);

	assign s_tready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid && !s_tuser) state_q <= S_UZ0;
				S_UZ0:  state_q <= S_UZ1;
				S_UZ1:  state_q <= S_UZF;
				S_UZF:  state_q <= S_UX0;
				S_UX0:  state_q <= S_UX1;
				S_UX1:  state_q <= S_UY0;
				S_UY0:  state_q <= S_UY1;
				S_UY1:  state_q <= S_CHK;
				S_CHK:  state_q <= inside_c ? S_N0 : S_OUT;
				S_N0:   state_q <= S_N1;
				S_N1:   state_q <= S_N2;
				S_N2:   state_q <= S_DST;
				S_DST:  state_q <= S_DIV;
				S_DIV:  if (div_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= last_pix ? S_IDLE : S_UX0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && s_tvalid && !s_tuser) begin
			ax_q    <= in_ax;
			ay_q    <= in_ay;
			az_q    <= s_tdata[39:24];
			bz_q    <= s_tdata[79:64];
			cz_q    <= s_tdata[119:104];
			paint_q <= s_tdata[143:120];
			x0_q    <= DIF_W'(in_bx) - DIF_W'(in_ax);
			x1_q    <= DIF_W'(in_cx) - DIF_W'(in_ax);
			y0_q    <= DIF_W'(in_by) - DIF_W'(in_ay);
			y1_q    <= DIF_W'(in_cy) - DIF_W'(in_ay);
			xlo_q   <= clamp_crd(mnx, XMAX);
			xhi_q   <= clamp_crd(mxx, XMAX);
			yhi_q   <= clamp_crd(mxy, YMAX);
			px_q    <= clamp_crd(mnx, XMAX);
			py_q    <= clamp_crd(mny, YMAX);
		end
		if (state_q == S_UZF) begin
			deg_q    <= (acc_crs == '0);
			uz_neg_q <= acc_crs[CRS_W-1];
			uz_q     <= acc_crs[CRS_W-1] ? CRS_W'(-acc_crs) : CRS_W'(acc_crs);
		end
		if (state_q == S_UY0) begin
			ux_q <= acc_fix;
		end
		if (state_q == S_CHK) begin
			uy_q     <= acc_fix;
			w0_q     <= w0_c[CRS_W-1:0];
			inside_q <= inside_c;
		end
		if (state_q == S_DST) begin
			num_neg_q <= acc[ACC_W-1];
		end
		if ((state_q == S_OUT) && out_free && !last_pix) begin
			if (px_q == xhi_q) begin
				px_q <= xlo_q;
				py_q <= py_q + 1'b1;
			end else begin
				px_q <= px_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			m_tdata <= {2'b00,
				drawn ? paint_q : {PNT_W{1'b0}},
				drawn ? depth : {DEP_W{1'b0}},
				py_q, px_q};
			m_tuser <= drawn;
			m_tlast <= last_pix;
		end
	end

`ifndef SYNTHESIS
	a_drawn_not_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[21:6] != DEPTH_MIN)
		else $error("drawn pixel carries most negative depth");

	a_undrawn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[45:6] == '0)
		else $error("undrawn pixel carries depth or color");

	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("result loaded outside output state");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && div_done |=> (state_q == S_OUT))
		else $error("divider finish not followed by output state");
`endif

endmodule
